// ===== design/csidb_pkg.sv =====
// Shared types and constants for the ordered byte list with insert and delete.
package csidb_pkg;

   localparam int unsigned CAPACITY_DEF = 64;
   localparam int unsigned CMD_W        = 3;
   localparam int unsigned INDEX_W      = 6;
   localparam int unsigned CHAR_W       = 8;
   localparam int unsigned COUNT_W      = 7;
   localparam int unsigned REQ_W        = 24;
   localparam int unsigned RSP_W        = 16;
   localparam int unsigned GROUP_SIZE   = 32;

   // Command codes carried in the request transaction
   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR  = 3'd0,
      CMD_APPEND = 3'd1,
      CMD_INSERT = 3'd2,
      CMD_REMOVE = 3'd3,
      CMD_MODIFY = 3'd4,
      CMD_READ   = 3'd5,
      CMD_SPLICE = 3'd6
   } cmd_type;

   // Action broadcast to every cell in the row
   typedef enum logic [2:0] {
      ACT_HOLD,
      ACT_WRITE,
      ACT_OPEN,
      ACT_CLOSE,
      ACT_READ
   } cell_act_type;

   typedef struct packed {
      cell_act_type        act;
      logic [CHAR_W-1:0]   data;
   } cell_ctrl_type;

endpackage

// ===== design/char_sequence_insert_delete_buffer.sv =====
// Top level of the ordered byte list: command decode, cell row and response pipeline.
//
// Usage:
//   Requests arrive on the req_ stream channel, one command per transaction:
//   clear, append, insert, remove, modify, read or splice, with an index and
//   a byte. Every request yields exactly one response on the rsp_ channel
//   carrying the byte read (zero unless an accepted read), the fill count
//   after the command, and an accepted flag.
//   The list lives in a row of CAPACITY cells; insert and remove shift the
//   cells from the index onward by one position in parallel in the cycle the
//   request is accepted. Stage one registers the per-group read taps of up to
//   GROUP_SIZE cells; the output register holds them merged.
//   Throughput is one command per cycle while the receiver takes the
//   responses.
//   When the receiver stalls, up to two responses are held in the pipeline
//   and req_tready drops once both are occupied.
//   Synchronous reset empties the list (fill count zero) and the pipeline and
//   holds req_tready low; cell contents are not cleared and are only read
//   after being written.
module char_sequence_insert_delete_buffer #(
   parameter int unsigned CAPACITY = csidb_pkg::CAPACITY_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // cmd[2:0], index[8:3], char_in[16:9], zero pad[23:17]
   input  logic [csidb_pkg::REQ_W-1:0]   req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // char_out[7:0], count[14:8], accepted[15]
   output logic [csidb_pkg::RSP_W-1:0]   rsp_tdata
);
   import csidb_pkg::*;

   localparam int unsigned CW     = $clog2(CAPACITY + 1);
   localparam int unsigned PW     = $clog2(CAPACITY);
   localparam int unsigned CMPW   = (CW > INDEX_W) ? CW : INDEX_W;
   localparam int unsigned NGROUP = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

   // Request fields
   cmd_type             req_cmd;
   logic [INDEX_W-1:0]  req_index;
   logic [CHAR_W-1:0]   req_char;
   logic                req_accept;

   // List state
   logic [CW-1:0]       fill_ff;
   logic [CW-1:0]       fill_in;
   logic [CMPW-1:0]     idx_cmp;
   logic [CMPW-1:0]     fill_cmp;
   logic                in_range;
   logic                has_room;
   logic                ok_w;

   // Cell row wiring
   cell_ctrl_type       ctrl;
   logic [PW-1:0]       pos;
   logic [CHAR_W-1:0]   cell_data [CAPACITY];
   logic [CHAR_W-1:0]   cell_tap  [CAPACITY];
   logic [CHAR_W-1:0]   left_w    [CAPACITY];
   logic [CHAR_W-1:0]   right_w   [CAPACITY];
   logic [CHAR_W-1:0]   group_or  [NGROUP];

   // Response pipeline
   logic                s1_valid_ff;
   logic                s1_valid_in;
   logic [CHAR_W-1:0]   s1_group_ff [NGROUP];
   logic [COUNT_W-1:0]  s1_count_ff;
   logic                s1_ok_ff;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [CHAR_W-1:0]   rsp_char_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic                rsp_ok_ff;
   logic [CHAR_W-1:0]   merged_char;
   logic                out_adv;

   // Unpack request
   assign req_cmd   = cmd_type'(req_tdata[CMD_W-1:0]);
   assign req_index = req_tdata[CMD_W +: INDEX_W];
   assign req_char  = req_tdata[CMD_W+INDEX_W +: CHAR_W];

   // Handshake: advance output when empty or drained, accept when stage one frees
   assign out_adv    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !reset && (!s1_valid_ff || out_adv);
   assign req_accept = req_tvalid && req_tready;

   // Range checks against the current fill count
   assign idx_cmp  = CMPW'(req_index);
   assign fill_cmp = CMPW'(fill_ff);
   assign in_range = (idx_cmp < fill_cmp);
   assign has_room = (fill_ff < CW'(CAPACITY));

   // Decode command into a cell action, position and new fill count
   always_comb begin
      ctrl.act  = ACT_HOLD;
      ctrl.data = req_char;
      pos       = idx_cmp[PW-1:0];
      fill_in   = fill_ff;
      ok_w      = 1'b0;
      if (req_accept) begin
         unique case (req_cmd)
            CMD_CLEAR: begin
               fill_in = '0;
               ok_w    = 1'b1;
            end
            CMD_APPEND: begin
               if (has_room) begin
                  ctrl.act = ACT_WRITE;
                  pos      = fill_ff[PW-1:0];
                  fill_in  = fill_ff + CW'(1);
                  ok_w     = 1'b1;
               end
            end
            CMD_INSERT: begin
               if (has_room && in_range) begin
                  ctrl.act = ACT_OPEN;
                  fill_in  = fill_ff + CW'(1);
                  ok_w     = 1'b1;
               end
            end
            CMD_REMOVE: begin
               if (in_range) begin
                  ctrl.act = ACT_CLOSE;
                  fill_in  = fill_ff - CW'(1);
                  ok_w     = 1'b1;
               end
            end
            CMD_MODIFY: begin
               if (in_range) begin
                  ctrl.act = ACT_WRITE;
                  ok_w     = 1'b1;
               end
            end
            CMD_READ: begin
               if (in_range) begin
                  ctrl.act = ACT_READ;
                  ok_w     = 1'b1;
               end
            end
            CMD_SPLICE: begin
               if (in_range) begin
                  // Open a gap; the last byte drops off when full
                  ctrl.act = ACT_OPEN;
                  if (has_room) fill_in = fill_ff + CW'(1);
                  ok_w     = 1'b1;
               end else if (has_room) begin
                  ctrl.act = ACT_WRITE;
                  pos      = fill_ff[PW-1:0];
                  fill_in  = fill_ff + CW'(1);
                  ok_w     = 1'b1;
               end
            end
            default: begin
               ok_w = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // Row of cells, each linked to its left and right neighbor
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_left_edge
         assign left_w[i] = '0;
      end else begin : g_left
         assign left_w[i] = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_right_edge
         assign right_w[i] = cell_data[i];
      end else begin : g_right
         assign right_w[i] = cell_data[i+1];
      end

      csidb_cell #(
         .POS_W    (PW),
         .CELL_IDX (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .pos        (pos),
         .left_data  (left_w[i]),
         .right_data (right_w[i]),
         .data_out   (cell_data[i]),
         .read_tap   (cell_tap[i])
      );
   end

   // Merge read taps within each group
   always_comb begin
      for (int g = 0; g < NGROUP; g++) begin
         group_or[g] = '0;
         for (int k = 0; k < GROUP_SIZE; k++) begin
            if (g * GROUP_SIZE + k < CAPACITY) begin
               group_or[g] = group_or[g] | cell_tap[g * GROUP_SIZE + k];
            end
         end
      end
   end

   // Stage one: group taps, count and flag
   assign s1_valid_in = req_tready ? req_accept : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         for (int g = 0; g < NGROUP; g++) begin
            s1_group_ff[g] <= group_or[g];
         end
         s1_count_ff <= COUNT_W'(fill_in);
         s1_ok_ff    <= ok_w;
      end
   end

   // Merge groups into the final read byte
   always_comb begin
      merged_char = '0;
      for (int g = 0; g < NGROUP; g++) begin
         merged_char = merged_char | s1_group_ff[g];
      end
   end

   // Output register
   assign rsp_valid_in = out_adv ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv && s1_valid_ff) begin
         rsp_char_ff  <= merged_char;
         rsp_count_ff <= s1_count_ff;
         rsp_ok_ff    <= s1_ok_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ok_ff, rsp_count_ff, rsp_char_ff};

`ifndef SYNTHESIS
   // Fill count never passes the capacity
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(CAPACITY))
      else $error("fill count above capacity");

   // A refused command never returns a byte
   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ok_ff) |-> (rsp_char_ff == '0))
      else $error("refused command returned data");

   // Clear empties the list
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_cmd == CMD_CLEAR) |=> (fill_ff == '0))
      else $error("clear left entries");

   // Read and modify keep the count
   a_count_kept: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_cmd == CMD_READ || req_cmd == CMD_MODIFY)) |=> $stable(fill_ff))
      else $error("read or modify changed the count");

   // Stage one never holds a response while the output stage is empty and free
   a_pipe_drain: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("response stuck in stage one");
`endif

endmodule

// ===== design/csidb_cell.sv =====
// One storage cell of the byte row: holds, loads or takes a neighbor's byte.
module csidb_cell #(
   parameter int unsigned POS_W    = 6,
   parameter int unsigned CELL_IDX = 0
) (
   input  logic                            clock,
   input  csidb_pkg::cell_ctrl_type        ctrl,
   input  logic [POS_W-1:0]                pos,
   input  logic [csidb_pkg::CHAR_W-1:0]    left_data,
   input  logic [csidb_pkg::CHAR_W-1:0]    right_data,
   output logic [csidb_pkg::CHAR_W-1:0]    data_out,
   output logic [csidb_pkg::CHAR_W-1:0]    read_tap
);
   import csidb_pkg::*;

   logic [CHAR_W-1:0] data_ff;
   logic [CHAR_W-1:0] data_in;
   logic              here_w;
   logic              after_w;

   // Locate this cell relative to the command position
   assign here_w  = (pos == POS_W'(CELL_IDX));
   assign after_w = (POS_W'(CELL_IDX) > pos);

   // Pick the next byte: hold, load, take left (open gap) or take right (close gap)
   always_comb begin
      data_in = data_ff;
      unique case (ctrl.act)
         ACT_WRITE: begin
            if (here_w) data_in = ctrl.data;
         end
         ACT_OPEN: begin
            if (here_w) data_in = ctrl.data;
            else if (after_w) data_in = left_data;
         end
         ACT_CLOSE: begin
            if (here_w || after_w) data_in = right_data;
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   // Expose the byte only when this cell is the read target
   assign read_tap = (ctrl.act == ACT_READ && here_w) ? data_ff : '0;
   assign data_out = data_ff;

endmodule

// ===== tb/tb_char_sequence_insert_delete_buffer.sv =====
// Self-checking testbench for the ordered byte list with insert and delete.
`timescale 1ns / 100ps

module tb_char_sequence_insert_delete_buffer;
   import csidb_pkg::*;

   localparam int unsigned CAPACITY     = CAPACITY_DEF;
   localparam int unsigned RANDOM_ITEMS = 950;
   localparam int unsigned HOLD_CYCLES  = 200;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned STALL_LIMIT  = 2000;
   localparam int unsigned CALM_START   = 400;
   localparam int unsigned CALM_STOP    = 600;
   // Command code outside the defined set; the block must ignore it
   localparam cmd_type CMD_UNUSED = cmd_type'(3'd7);

   // Request fields, lowest bits last in the declaration
   typedef struct packed {
      logic [CHAR_W-1:0]  char_in;
      logic [INDEX_W-1:0] index;
      cmd_type            cmd;
   } list_req_type;

   // Response fields as packed in rsp_tdata
   typedef struct packed {
      logic               accepted;
      logic [COUNT_W-1:0] count;
      logic [CHAR_W-1:0]  char_out;
   } list_reply_type;

   typedef struct {
      list_req_type   req;
      int unsigned    reps;
      bit             typed;
      list_reply_type reply;
   } script_row_type;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata  = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;

   // Shadow copy of the list
   logic [CHAR_W-1:0] list_bytes [CAPACITY];
   int unsigned       list_len = 0;

   list_reply_type    pending_replies [$];
   script_row_type    script [$];
   int unsigned       error_count  = 0;
   bit                calm         = 1'b0;
   bit                hold_off_req = 1'b0;
   int unsigned       hold_left    = 0;
   int unsigned       quiet_cycles = 0;

   char_sequence_insert_delete_buffer #(.CAPACITY(CAPACITY)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Open a gap at pos and store the byte there, dropping the last byte when full
   function automatic void open_gap(input int unsigned pos, input logic [CHAR_W-1:0] value);
      int unsigned top;
      top = list_len;
      if (top >= CAPACITY) begin
         top = CAPACITY - 1;
      end else begin
         list_len++;
      end
      for (int unsigned i = top; i > pos; i--) list_bytes[i] = list_bytes[i-1];
      list_bytes[pos] = value;
   endfunction

   // Apply one command to the shadow list and return the response it yields
   function automatic list_reply_type apply_list_cmd(input list_req_type req);
      list_reply_type reply;
      bit             in_range;
      bit             has_room;
      reply    = '0;
      in_range = req.index < list_len;
      has_room = list_len < CAPACITY;
      case (req.cmd)
         CMD_CLEAR: begin
            list_len       = 0;
            reply.accepted = 1'b1;
         end
         CMD_APPEND: if (has_room) begin
            list_bytes[list_len] = req.char_in;
            list_len++;
            reply.accepted = 1'b1;
         end
         CMD_INSERT: if (has_room && in_range) begin
            open_gap(req.index, req.char_in);
            reply.accepted = 1'b1;
         end
         CMD_REMOVE: if (in_range) begin
            for (int unsigned i = req.index; i + 1 < list_len; i++)
               list_bytes[i] = list_bytes[i+1];
            list_len--;
            reply.accepted = 1'b1;
         end
         CMD_MODIFY: if (in_range) begin
            list_bytes[req.index] = req.char_in;
            reply.accepted = 1'b1;
         end
         CMD_READ: if (in_range) begin
            reply.char_out = list_bytes[req.index];
            reply.accepted = 1'b1;
         end
         CMD_SPLICE: begin
            if (in_range) begin
               open_gap(req.index, req.char_in);
               reply.accepted = 1'b1;
            end else if (has_room) begin
               list_bytes[list_len] = req.char_in;
               list_len++;
               reply.accepted = 1'b1;
            end
         end
         default: ;
      endcase
      reply.count = COUNT_W'(list_len);
      return reply;
   endfunction

   function automatic void add_row(input cmd_type cmd, input logic [INDEX_W-1:0] index,
                                   input logic [CHAR_W-1:0] ch, input int unsigned reps,
                                   input bit typed, input logic [CHAR_W-1:0] exp_char,
                                   input logic [COUNT_W-1:0] exp_count, input logic exp_acc);
      script_row_type row;
      row.req   = '{char_in: ch, index: index, cmd: cmd};
      row.reps  = reps;
      row.typed = typed;
      row.reply = '{accepted: exp_acc, count: exp_count, char_out: exp_char};
      script.push_back(row);
   endfunction

   // Index mostly inside the list, now and then at its end or anywhere
   function automatic logic [INDEX_W-1:0] pick_index();
      int unsigned roll;
      roll = $urandom_range(99);
      if (list_len != 0 && roll < 80) return INDEX_W'($urandom_range(list_len - 1, 0));
      if (roll < 88) return INDEX_W'(list_len);
      return INDEX_W'($urandom_range((1 << INDEX_W) - 1, 0));
   endfunction

   // Offer one transaction after a random gap, then record its expected response
   task automatic issue_cmd(input list_req_type req, input bit typed,
                            input list_reply_type typed_reply);
      int unsigned    gap;
      list_reply_type reply;
      gap = 0;
      if (!calm) while ($urandom_range(99) < 25) gap++;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_W - $bits(list_req_type)){1'b0}}, req};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      reply = apply_list_cmd(req);
      pending_replies.push_back(typed ? typed_reply : reply);
   endtask

   // Drive the response ready, with a long hold-off when asked for
   always @(posedge clock) begin
      if (hold_off_req) begin
         hold_off_req = 1'b0;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || ($urandom_range(99) >= 25);
      end
   end

   // Compare each response transaction with the oldest expectation
   always @(posedge clock) begin
      list_reply_type got;
      list_reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = list_reply_type'(rsp_tdata);
         if (pending_replies.size() == 0) begin
            $display("%0t: response with none outstanding, tdata %h", $time, rsp_tdata);
            error_count++;
         end else begin
            want = pending_replies.pop_front();
            if (got.char_out !== want.char_out) begin
               $display("%0t: char_out expected %h actual %h", $time, want.char_out,
                        got.char_out);
               error_count++;
            end
            if (got.count !== want.count) begin
               $display("%0t: count expected %0d actual %0d", $time, want.count, got.count);
               error_count++;
            end
            if (got.accepted !== want.accepted) begin
               $display("%0t: accepted expected %b actual %b", $time, want.accepted,
                        got.accepted);
               error_count++;
            end
         end
      end
   end

   // End the run when neither channel moves for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
            $display("char_sequence_insert_delete_buffer: mismatch");
            $finish;
         end
      end
   end

   initial begin
      list_req_type   req;
      list_reply_type none;
      int unsigned    sent;
      int unsigned    burst_kind;
      int unsigned    burst_len;
      int unsigned    roll;
      bit             pressure_done;

      none          = '0;
      sent          = 0;
      pressure_done = 1'b0;

      // Empty list: refusals, splice past the end, unused code, first reads
      add_row(CMD_READ,   6'd0,  8'h00, 1, 1, 8'h00, 7'd0,  1'b0);
      add_row(CMD_REMOVE, 6'd0,  8'h00, 1, 1, 8'h00, 7'd0,  1'b0);
      add_row(CMD_MODIFY, 6'd63, 8'hFF, 1, 1, 8'h00, 7'd0,  1'b0);
      add_row(CMD_INSERT, 6'd0,  8'hAA, 1, 1, 8'h00, 7'd0,  1'b0);
      add_row(CMD_SPLICE, 6'd63, 8'hFF, 1, 1, 8'h00, 7'd1,  1'b1);
      add_row(CMD_APPEND, 6'd0,  8'h00, 1, 1, 8'h00, 7'd2,  1'b1);
      add_row(CMD_UNUSED, 6'd0,  8'h55, 1, 1, 8'h00, 7'd2,  1'b0);
      add_row(CMD_READ,   6'd0,  8'h00, 1, 1, 8'hFF, 7'd2,  1'b1);
      add_row(CMD_INSERT, 6'd1,  8'h80, 1, 0, 8'h00, 7'd0,  1'b0);
      add_row(CMD_MODIFY, 6'd2,  8'h7F, 1, 0, 8'h00, 7'd0,  1'b0);
      add_row(CMD_READ,   6'd2,  8'h00, 1, 0, 8'h00, 7'd0,  1'b0);
      add_row(CMD_REMOVE, 6'd0,  8'h00, 1, 0, 8'h00, 7'd0,  1'b0);
      add_row(CMD_CLEAR,  6'd0,  8'h00, 1, 1, 8'h00, 7'd0,  1'b1);
      // Fill to capacity, then hit every full-list case
      add_row(CMD_APPEND, 6'd0,  8'h01, 63, 0, 8'h00, 7'd0, 1'b0);
      add_row(CMD_INSERT, 6'd0,  8'hEE, 1, 0, 8'h00, 7'd0,  1'b0);
      add_row(CMD_APPEND, 6'd0,  8'h11, 1, 1, 8'h00, 7'd64, 1'b0);
      add_row(CMD_INSERT, 6'd5,  8'h44, 1, 1, 8'h00, 7'd64, 1'b0);
      add_row(CMD_SPLICE, 6'd63, 8'h22, 1, 1, 8'h00, 7'd64, 1'b1);
      add_row(CMD_SPLICE, 6'd0,  8'h33, 1, 1, 8'h00, 7'd64, 1'b1);
      add_row(CMD_READ,   6'd63, 8'h00, 1, 0, 8'h00, 7'd0,  1'b0);
      add_row(CMD_MODIFY, 6'd63, 8'hFF, 1, 0, 8'h00, 7'd0,  1'b0);
      add_row(CMD_READ,   6'd63, 8'h00, 1, 1, 8'hFF, 7'd64, 1'b1);
      add_row(CMD_REMOVE, 6'd63, 8'h00, 1, 0, 8'h00, 7'd0,  1'b0);
      add_row(CMD_SPLICE, 6'd63, 8'h5A, 1, 0, 8'h00, 7'd0,  1'b0);
      // Drain from the front down to empty
      add_row(CMD_REMOVE, 6'd0,  8'h00, 64, 0, 8'h00, 7'd0, 1'b0);
      add_row(CMD_REMOVE, 6'd0,  8'h00, 1, 1, 8'h00, 7'd0,  1'b0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table
      foreach (script[r]) begin
         for (int unsigned k = 0; k < script[r].reps; k++) begin
            req = script[r].req;
            req.char_in = req.char_in + CHAR_W'(k);
            issue_cmd(req, script[r].typed, script[r].reply);
         end
      end

      // Random bursts: mixed traffic, growth to full, draining, reads, noise
      while (sent < RANDOM_ITEMS) begin
         burst_kind = $urandom_range(9);
         burst_len  = (burst_kind == 4 || burst_kind == 5) ? $urandom_range(80, 40)
                                                           : $urandom_range(40, 8);
         for (int unsigned n = 0; n < burst_len && sent < RANDOM_ITEMS; n++) begin
            // hold the receiver off once, and keep a stretch free of idling
            if (!pressure_done && sent >= CALM_START) begin
               pressure_done = 1'b1;
               calm          = 1'b1;
               hold_off_req  = 1'b1;
            end
            if (calm && sent >= CALM_STOP) calm = 1'b0;

            req.char_in = CHAR_W'($urandom_range(255));
            req.index   = pick_index();
            roll        = $urandom_range(99);
            case (burst_kind)
               4, 5: begin
                  if (roll < 30)      req.cmd = CMD_APPEND;
                  else if (roll < 60) req.cmd = CMD_INSERT;
                  else                req.cmd = CMD_SPLICE;
               end
               6: req.cmd = (roll < 80) ? CMD_REMOVE : CMD_READ;
               7: begin
                  req.cmd   = cmd_type'($urandom_range(7));
                  req.index = INDEX_W'($urandom_range((1 << INDEX_W) - 1));
               end
               8: req.cmd = (roll < 60) ? CMD_READ : CMD_MODIFY;
               default: begin
                  if (roll < 3)       req.cmd = CMD_CLEAR;
                  else if (roll < 23) req.cmd = CMD_APPEND;
                  else if (roll < 38) req.cmd = CMD_INSERT;
                  else if (roll < 53) req.cmd = CMD_REMOVE;
                  else if (roll < 68) req.cmd = CMD_MODIFY;
                  else if (roll < 83) req.cmd = CMD_READ;
                  else                req.cmd = CMD_SPLICE;
               end
            endcase
            issue_cmd(req, 1'b0, none);
            sent++;
         end
      end
      req_tvalid <= 1'b0;

      // Drain outstanding responses, then watch for strays
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("char_sequence_insert_delete_buffer: match");
      end else begin
         $display("char_sequence_insert_delete_buffer: mismatch");
      end
      $finish;
   end

endmodule
